### hdl/scm_pkg.sv
`timescale 1ns / 1ps
// shared constants, field widths and command codes for the size class rebinning block
package scm_pkg;

  // fixed field widths
  localparam int CMD_W      = 2;
  localparam int SLOT_W     = 4;
  localparam int SIZE_W     = 16;
  localparam int MASS_W     = 32;
  localparam int NUM_W      = 4;
  localparam int OUT_TOT_W  = 40;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_ADDR_W = 1;

  // stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;

  // defaults of the top level parameters
  localparam int MAX_CLASSES_DEF = 16;
  localparam int TOTAL_BITS_DEF  = 40;

  // command codes carried on the input side band
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_DEPOSIT = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_READOUT = 2'd3
  } cmd_e;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_SPLIT_MODE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CLASSES    = 1'd1;

endpackage

### hdl/scm_divider.sv
`timescale 1ns / 1ps
// serial restoring divider, one quotient bit per cycle
module scm_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [scm_pkg::SIZE_W-1:0] hi_i,
  input  logic [scm_pkg::MASS_W-1:0] lo_i,
  input  logic [scm_pkg::SIZE_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [scm_pkg::MASS_W-1:0] quot_o
);

  localparam int CW = $clog2(scm_pkg::MASS_W);

  logic                       busy_q;
  logic [CW-1:0]              cnt_q;
  logic [scm_pkg::SIZE_W-1:0] rem_q;
  logic [scm_pkg::MASS_W-1:0] quo_q;
  logic [scm_pkg::SIZE_W-1:0] div_q;

  logic [scm_pkg::SIZE_W:0]   trial;
  logic [scm_pkg::SIZE_W:0]   trial_sub;
  logic                       take;
  logic [scm_pkg::SIZE_W-1:0] rem_n;
  logic [scm_pkg::MASS_W-1:0] quo_n;

  // remainder stays below the divisor, so the trial fits one extra bit
  assign trial     = {rem_q, quo_q[scm_pkg::MASS_W-1]};
  assign trial_sub = trial - {1'b0, div_q};
  assign take      = (trial >= {1'b0, div_q});
  assign rem_n     = take ? trial_sub[scm_pkg::SIZE_W-1:0] : trial[scm_pkg::SIZE_W-1:0];
  assign quo_n     = {quo_q[scm_pkg::MASS_W-2:0], take};

  assign done_o = busy_q && (cnt_q == CW'(scm_pkg::MASS_W - 1));
  assign quot_o = quo_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      div_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      rem_q  <= hi_i;
      quo_q  <= lo_i;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
      cnt_q <= cnt_q + CW'(1);
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

### hdl/size_class_mass_rebinning.sv
`timescale 1ns / 1ps
// top level: class size table, saturating class accumulators and command sequencer
// load and clear finish in idle. a deposit scans the classes in use; a proportional
// split then multiplies, runs the serial divider and updates both classes, others
// update one class. a read-out checks size order, then emits the totals in turn,
// held by a busy output. reset is asynchronous active low: split_mode 1, one class
// in use, all totals and saturation marks zero, class sizes undefined until loaded
module size_class_mass_rebinning #(
  parameter int MAX_CLASSES = scm_pkg::MAX_CLASSES_DEF,
  parameter int TOTAL_BITS  = scm_pkg::TOTAL_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [scm_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [scm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // command items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // class_slot [3:0], item_size [19:4], item_mass [51:20], zero fill
  input  logic [scm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // cmd [1:0]
  input  logic [scm_pkg::CMD_W-1:0]      s_axis_tuser,
  // class total items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // class_number [3:0], class_total [43:4], total_saturated [44], order_fault [45], zero fill
  output logic [scm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // last_total
  output logic                           m_axis_tlast
);

  localparam int IDXW  = $clog2(MAX_CLASSES);
  localparam int CNTW  = $clog2(MAX_CLASSES + 1);
  localparam int ENTW  = TOTAL_BITS + 1;
  localparam int SW    = scm_pkg::SIZE_W;
  localparam int MW    = scm_pkg::MASS_W;
  localparam int PRODW = SW + MW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_RO_RD,
    ST_RO_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic                           split_mode_q;
  logic [scm_pkg::CFG_DATA_W-1:0] classes_q;

  // latched command item
  scm_pkg::cmd_e   cmd_q;
  logic [SW-1:0]   size_q;
  logic [MW-1:0]   mass_q;
  logic [CNTW-1:0] n_q;

  // scan pipeline: k_q issues reads, pi_q is the entry whose size sits in size_rd_q
  logic [CNTW-1:0] k_q;
  logic            pv_q;
  logic [IDXW-1:0] pi_q;
  logic [SW-1:0]   prev_q;
  logic [SW:0]     best_d_q;
  logic [IDXW-1:0] best_idx_q;
  logic            fault_q;

  // proportional split operands
  logic [SW-1:0]    up_q;
  logic [SW-1:0]    range_q;
  logic [IDXW-1:0]  j_q;
  logic [PRODW-1:0] prod_q;

  // accumulator updates, at most two per deposit
  logic [IDXW-1:0] add_idx_q;
  logic [MW-1:0]   add_amt_q;
  logic            add2_pend_q;
  logic [IDXW-1:0] add2_idx_q;
  logic [MW-1:0]   add2_amt_q;

  // read-out and output register
  logic [IDXW-1:0]             ro_i_q;
  logic                        m_valid_q;
  logic [scm_pkg::NUM_W-1:0]   m_num_q;
  logic [scm_pkg::OUT_TOT_W-1:0] m_total_q;
  logic                        m_sat_q;
  logic                        m_fault_q;
  logic                        m_last_q;

  // memories and the per entry valid bits of the totals
  logic [SW-1:0]          size_mem [MAX_CLASSES];
  logic [SW-1:0]          size_rd_q;
  logic [ENTW-1:0]        tot_mem [MAX_CLASSES];
  logic [ENTW-1:0]        tot_rd_q;
  logic                   tot_rdv_q;
  logic [MAX_CLASSES-1:0] tot_vld_q;

  // input field unpacking
  logic [scm_pkg::SLOT_W-1:0] in_slot;
  logic [SW-1:0]              in_size;
  logic [MW-1:0]              in_mass;
  scm_pkg::cmd_e              in_cmd;
  logic                       s_acc;
  logic                       load_we;
  logic [CNTW-1:0]            n_eff;

  assign in_slot = s_axis_tdata[3:0];
  assign in_size = s_axis_tdata[19:4];
  assign in_mass = s_axis_tdata[51:20];
  assign in_cmd  = scm_pkg::cmd_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  // slots beyond the table are dropped
  assign load_we       = s_acc && (in_cmd == scm_pkg::CMD_LOAD)
                         && (int'(in_slot) < MAX_CLASSES);

  // class count clamped into 1..MAX_CLASSES
  always_comb begin
    if (classes_q == '0) begin
      n_eff = CNTW'(1);
    end else if (int'(classes_q) > MAX_CLASSES) begin
      n_eff = CNTW'(MAX_CLASSES);
    end else begin
      n_eff = CNTW'(classes_q);
    end
  end

  // size table: written by loads, read one entry a cycle by the scan
  logic [IDXW-1:0] size_raddr;
  assign size_raddr = k_q[IDXW-1:0];

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      size_mem[IDXW'(in_slot)] <= in_size;
    end
    size_rd_q <= size_mem[size_raddr];
  end

  // scan compare unit, shared by nearest search, split search and order check
  logic [SW-1:0] diff;
  logic          better;
  logic          ge;
  logic          last_proc;

  assign ge        = (size_rd_q >= size_q);
  assign diff      = ge ? (size_rd_q - size_q) : (size_q - size_rd_q);
  assign better    = ({1'b0, diff} < best_d_q);
  assign last_proc = ((CNTW'(pi_q) + CNTW'(1)) == n_q);

  // split product, registered before the divider takes it
  logic [PRODW-1:0] prod;
  assign prod = PRODW'(mass_q) * PRODW'(up_q);

  // the high part of the product is below the range, so the quotient fits the mass width
  logic          div_start;
  logic          div_done;
  logic [MW-1:0] div_quot;

  assign div_start = (state_q == ST_DIVGO);

  scm_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .hi_i      (prod_q[PRODW-1:MW]),
    .lo_i      (prod_q[MW-1:0]),
    .divisor_i (range_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // totals memory: read-modify-write for deposits, plain reads for read-out
  logic [IDXW-1:0]       tot_raddr;
  logic [TOTAL_BITS-1:0] cur_total;
  logic                  cur_mark;
  logic [TOTAL_BITS:0]   sum;
  logic [TOTAL_BITS-1:0] new_total;
  logic                  new_mark;
  logic                  tot_we;

  assign tot_raddr = ((state_q == ST_RO_RD) || (state_q == ST_RO_OUT)) ? ro_i_q : add_idx_q;

  // an entry never written since the last clear reads as zero
  assign cur_total = tot_rdv_q ? tot_rd_q[TOTAL_BITS-1:0] : '0;
  assign cur_mark  = tot_rdv_q & tot_rd_q[TOTAL_BITS];
  assign sum       = {1'b0, cur_total} + (TOTAL_BITS + 1)'(add_amt_q);
  // saturate on carry out, mark also when the maximum is hit exactly
  assign new_total = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
  assign new_mark  = cur_mark | (&new_total);
  assign tot_we    = (state_q == ST_ADD_WR);

  always_ff @(posedge clk_i) begin
    if (tot_we) begin
      tot_mem[add_idx_q] <= {new_mark, new_total};
    end
    tot_rd_q  <= tot_mem[tot_raddr];
    tot_rdv_q <= tot_vld_q[tot_raddr];
  end

  // sequencer with config registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      split_mode_q <= 1'b1;
      classes_q    <= scm_pkg::CFG_DATA_W'(1);
      cmd_q        <= scm_pkg::CMD_LOAD;
      size_q       <= '0;
      mass_q       <= '0;
      n_q          <= CNTW'(1);
      k_q          <= '0;
      pv_q         <= 1'b0;
      pi_q         <= '0;
      prev_q       <= '0;
      best_d_q     <= '1;
      best_idx_q   <= '0;
      fault_q      <= 1'b0;
      up_q         <= '0;
      range_q      <= '0;
      j_q          <= '0;
      prod_q       <= '0;
      add_idx_q    <= '0;
      add_amt_q    <= '0;
      add2_pend_q  <= 1'b0;
      add2_idx_q   <= '0;
      add2_amt_q   <= '0;
      ro_i_q       <= '0;
      m_valid_q    <= 1'b0;
      m_num_q      <= '0;
      m_total_q    <= '0;
      m_sat_q      <= 1'b0;
      m_fault_q    <= 1'b0;
      m_last_q     <= 1'b0;
      tot_vld_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          scm_pkg::CFG_SPLIT_MODE: split_mode_q <= cfg_data_i[0];
          scm_pkg::CFG_CLASSES:    classes_q    <= cfg_data_i;
          default: ;
        endcase
      end

      // output item taken downstream; a new load below overrides
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            cmd_q  <= in_cmd;
            size_q <= in_size;
            mass_q <= in_mass;
            n_q    <= n_eff;
            case (in_cmd)
              scm_pkg::CMD_DEPOSIT: begin
                k_q      <= '0;
                pv_q     <= 1'b0;
                best_d_q <= '1;
                state_q  <= ST_SCAN;
              end
              scm_pkg::CMD_CLEAR: begin
                tot_vld_q <= '0;
              end
              scm_pkg::CMD_READOUT: begin
                k_q     <= '0;
                pv_q    <= 1'b0;
                fault_q <= 1'b0;
                state_q <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end

        ST_SCAN: begin
          // issue the next size read while the previous one is checked
          if (k_q < n_q) begin
            k_q  <= k_q + CNTW'(1);
            pv_q <= 1'b1;
          end else begin
            pv_q <= 1'b0;
          end
          pi_q <= k_q[IDXW-1:0];

          if (pv_q) begin
            prev_q <= size_rd_q;
            case (cmd_q)
              scm_pkg::CMD_READOUT: begin
                // sizes must rise strictly
                if ((pi_q != '0) && (size_rd_q <= prev_q)) begin
                  fault_q <= 1'b1;
                end
                if (last_proc) begin
                  ro_i_q  <= '0;
                  state_q <= ST_RO_RD;
                end
              end
              scm_pkg::CMD_DEPOSIT: begin
                if (!split_mode_q) begin
                  // nearest class, strict compare keeps the lowest index on a tie
                  if (better) begin
                    best_d_q   <= {1'b0, diff};
                    best_idx_q <= pi_q;
                  end
                  if (last_proc) begin
                    add_idx_q   <= better ? pi_q : best_idx_q;
                    add_amt_q   <= mass_q;
                    add2_pend_q <= 1'b0;
                    state_q     <= ST_ADD_RD;
                  end
                end else if (ge) begin
                  // first class at or above the size
                  if ((pi_q == '0) || (size_rd_q == size_q)) begin
                    add_idx_q   <= pi_q;
                    add_amt_q   <= mass_q;
                    add2_pend_q <= 1'b0;
                    state_q     <= ST_ADD_RD;
                  end else begin
                    up_q    <= size_rd_q - size_q;
                    range_q <= size_rd_q - prev_q;
                    j_q     <= pi_q;
                    state_q <= ST_MUL;
                  end
                end else if (last_proc) begin
                  // above the whole table: end class takes all
                  add_idx_q   <= pi_q;
                  add_amt_q   <= mass_q;
                  add2_pend_q <= 1'b0;
                  state_q     <= ST_ADD_RD;
                end
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end

        ST_MUL: begin
          prod_q  <= prod;
          state_q <= ST_DIVGO;
        end

        ST_DIVGO: begin
          state_q <= ST_DIVWAIT;
        end

        ST_DIVWAIT: begin
          if (div_done) begin
            // lower class gets the floored share, upper class the rest
            add_idx_q   <= j_q - IDXW'(1);
            add_amt_q   <= div_quot;
            add2_pend_q <= 1'b1;
            add2_idx_q  <= j_q;
            add2_amt_q  <= mass_q - div_quot;
            state_q     <= ST_ADD_RD;
          end
        end

        ST_ADD_RD: begin
          state_q <= ST_ADD_WR;
        end

        ST_ADD_WR: begin
          tot_vld_q[add_idx_q] <= 1'b1;
          if (add2_pend_q) begin
            add_idx_q   <= add2_idx_q;
            add_amt_q   <= add2_amt_q;
            add2_pend_q <= 1'b0;
            state_q     <= ST_ADD_RD;
          end else begin
            state_q <= ST_IDLE;
          end
        end

        ST_RO_RD: begin
          state_q <= ST_RO_OUT;
        end

        ST_RO_OUT: begin
          // load the output register once it is free
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_num_q   <= scm_pkg::NUM_W'(ro_i_q);
            m_total_q <= scm_pkg::OUT_TOT_W'(cur_total);
            m_sat_q   <= cur_mark;
            m_fault_q <= fault_q;
            m_last_q  <= last_ro;
            if (last_ro) begin
              state_q <= ST_IDLE;
            end else begin
              ro_i_q  <= ro_i_q + IDXW'(1);
              state_q <= ST_RO_RD;
            end
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // final class of a read-out
  logic last_ro;
  assign last_ro = ((CNTW'(ro_i_q) + CNTW'(1)) == n_q);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, m_fault_q, m_sat_q, m_total_q, m_num_q};
  assign m_axis_tlast  = m_last_q;

endmodule

### test/size_class_mass_rebinning_checker.sv
`timescale 1ns / 1ps
// checker for the size class rebinning block: predicts class total items and compares them
module size_class_mass_rebinning_checker
  import scm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // class_slot [3:0], item_size [19:4], item_mass [51:20], zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd [1:0]
  input  logic [CMD_W-1:0]      s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // class_number [3:0], class_total [43:4], total_saturated [44], order_fault [45], zero fill
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  // last_total
  input  logic                  m_axis_tlast,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int NCLS = MAX_CLASSES_DEF;
  localparam logic [63:0] TOTAL_MAX = (64'd1 << TOTAL_BITS_DEF) - 64'd1;

  typedef struct packed {
    logic [NUM_W-1:0]     number;
    logic [OUT_TOT_W-1:0] total;
    logic                 saturated;
    logic                 order_fault;
    logic                 last;
  } class_report_t;

  logic                  split_mode;
  logic [CFG_DATA_W-1:0] classes_cfg;
  logic [SIZE_W-1:0]     size_tbl [NCLS];
  logic [63:0]           mass_tot [NCLS];
  logic                  sat_mark [NCLS];
  class_report_t         class_report_q [$];
  int                    mismatches;

  function automatic int classes_used();
    if (classes_cfg == '0) return 1;
    if (classes_cfg > NCLS) return NCLS;
    return int'(classes_cfg);
  endfunction

  // saturating add, mark also set when the maximum is hit exactly
  function automatic void accumulate(input int k, input logic [63:0] amount);
    logic [63:0] t;
    t = mass_tot[k] + amount;
    if (t >= TOTAL_MAX) begin
      t = TOTAL_MAX;
      sat_mark[k] = 1'b1;
    end
    mass_tot[k] = t;
  endfunction

  function automatic void deposit_nearest(input logic [SIZE_W-1:0] sz,
                                          input logic [MASS_W-1:0] m);
    int          best;
    logic [16:0] d;
    logic [16:0] best_d;
    best   = 0;
    best_d = 17'h1ffff;
    for (int j = 0; j < classes_used(); j++) begin
      d = (size_tbl[j] > sz) ? 17'(size_tbl[j] - sz) : 17'(sz - size_tbl[j]);
      // strict less keeps the lowest index on a tie
      if (d < best_d) begin
        best_d = d;
        best   = j;
      end
    end
    accumulate(best, 64'(m));
  endfunction

  function automatic void deposit_split(input logic [SIZE_W-1:0] sz,
                                        input logic [MASS_W-1:0] m);
    int          n;
    int          j;
    logic [63:0] span;
    logic [63:0] up_dist;
    logic [63:0] lower;
    n = classes_used();
    j = 0;
    while (j < n && size_tbl[j] < sz) j++;
    if (j >= n) begin
      accumulate(n - 1, 64'(m));
    end else if (j == 0 || size_tbl[j] == sz) begin
      accumulate(j, 64'(m));
    end else begin
      // lower share floored, upper class takes the remainder
      span    = 64'(size_tbl[j]) - 64'(size_tbl[j-1]);
      up_dist = 64'(size_tbl[j]) - 64'(sz);
      lower   = (64'(m) * up_dist) / span;
      accumulate(j - 1, lower);
      accumulate(j, 64'(m) - lower);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    class_report_t got;
    class_report_t want;
    logic          fault;
    int            n;
    if (!rst_ni) begin
      split_mode  = 1'b1;
      classes_cfg = CFG_DATA_W'(1);
      for (int i = 0; i < NCLS; i++) begin
        size_tbl[i] = '0;
        mass_tot[i] = '0;
        sat_mark[i] = 1'b0;
      end
      class_report_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_SPLIT_MODE: split_mode  = cfg_data_i[0];
          CFG_CLASSES:    classes_cfg = cfg_data_i;
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got.number      = m_axis_tdata[3:0];
        got.total       = m_axis_tdata[43:4];
        got.saturated   = m_axis_tdata[44];
        got.order_fault = m_axis_tdata[45];
        got.last        = m_axis_tlast;
        if (class_report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected class total item: number %0d total %h sat %b fault %b last %b",
                     got.number, got.total, got.saturated, got.order_fault, got.last);
        end else begin
          want = class_report_q.pop_front();
          if (got.number !== want.number || got.total !== want.total ||
              got.saturated !== want.saturated || got.order_fault !== want.order_fault ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"class total mismatch: number %0d/%0d total %h/%h sat %b/%b ",
                        "fault %b/%b last %b/%b (expected/actual)"},
                       want.number, got.number, want.total, got.total,
                       want.saturated, got.saturated, want.order_fault, got.order_fault,
                       want.last, got.last);
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        case (cmd_e'(s_axis_tuser))
          CMD_LOAD: size_tbl[s_axis_tdata[3:0]] = s_axis_tdata[19:4];
          CMD_DEPOSIT: begin
            if (split_mode) deposit_split(s_axis_tdata[19:4], s_axis_tdata[51:20]);
            else deposit_nearest(s_axis_tdata[19:4], s_axis_tdata[51:20]);
          end
          CMD_CLEAR: begin
            for (int i = 0; i < NCLS; i++) begin
              mass_tot[i] = '0;
              sat_mark[i] = 1'b0;
            end
          end
          default: begin
            n     = classes_used();
            fault = 1'b0;
            for (int i = 1; i < n; i++)
              if (size_tbl[i] <= size_tbl[i-1]) fault = 1'b1;
            for (int i = 0; i < n; i++) begin
              want.number      = NUM_W'(i);
              want.total       = mass_tot[i][OUT_TOT_W-1:0];
              want.saturated   = sat_mark[i];
              want.order_fault = fault;
              want.last        = (i == n - 1);
              class_report_q.push_back(want);
            end
          end
        endcase
      end

      fail_count_o <= mismatches;
      pending_o    <= class_report_q.size();
    end
  end

endmodule

### test/tb_size_class_mass_rebinning.sv
`timescale 1ns / 1ps
// testbench top: command stimulus, result back-pressure and verdict for the rebinning block
module tb_size_class_mass_rebinning;
  import scm_pkg::*;

  localparam int NCLS          = MAX_CLASSES_DEF;
  localparam int IDLE_PCT      = 37;      // per cycle chance of a gap on either side
  localparam int HOLD_CYCLES   = 400;     // long receiver hold-off, fills the block
  localparam int SETTLE_CYCLES = 100;     // settle time after a drain, lets the slowest deposit finish
  localparam int CYCLE_LIMIT   = 500000;  // far above the slowest correct run
  localparam int PHASE_ITEMS   = 27;      // six random phases, about 160 items

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // class_slot [3:0], item_size [19:4], item_mass [51:20], zero fill
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  // cmd [1:0]
  logic [CMD_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // class_number [3:0], class_total [43:4], total_saturated [44], order_fault [45], zero fill
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // last_total
  logic                  m_axis_tlast;

  int  fail_count;
  int  pending;
  int  cycle_cnt   = 0;
  bit  idle_on     = 1'b1;   // cleared for stretches with no gaps at all
  int  hold_reqs   = 0;      // bumped by the stimulus, served by the receiver
  int  hold_served = 0;
  int  used_n      = 1;      // effective class count, only to aim deposits
  logic [SIZE_W-1:0] size_tbl [NCLS];  // sizes as loaded, only to aim deposits

  size_class_mass_rebinning i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  size_class_mass_rebinning_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // watchdog on a hung block or lost items
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[size_class_mass_rebinning] ERROR");
      $finish;
    end
  end

  // result side: random stalls, and a long hold-off whenever one is requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_reqs) begin
        hold_served++;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // offer one command item with random gaps ahead, return on its handshake;
  // valid stays up so back-to-back items need no extra edge
  task automatic send_cmd(input cmd_e cmd, input logic [SLOT_W-1:0] slot,
                          input logic [SIZE_W-1:0] sz, input logic [MASS_W-1:0] m);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, m, sz, slot};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (cmd == CMD_LOAD) size_tbl[slot] = sz;
  endtask

  // stop offering and wait until every predicted class total has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // registers only change on an idle block: drain, then let a slow deposit finish
  task automatic set_mode(input logic split, input logic [CFG_DATA_W-1:0] classes);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_write(CFG_SPLIT_MODE, CFG_DATA_W'(split));
    cfg_write(CFG_CLASSES, classes);
    used_n = (classes == '0) ? 1 : ((classes > NCLS) ? NCLS : int'(classes));
  endtask

  // full table reload, ascending or scrambled
  task automatic load_table(input bit ascending);
    int v;
    v = $urandom_range(0, 300);
    for (int i = 0; i < NCLS; i++) begin
      send_cmd(CMD_LOAD, SLOT_W'(i), ascending ? SIZE_W'(v) : SIZE_W'($urandom), $urandom);
      v += $urandom_range(1, 4000);
    end
  endtask

  // deposit sizes aimed at the class edges, midpoints and the field extremes
  function automatic logic [SIZE_W-1:0] pick_size();
    int          j;
    logic [16:0] mid;
    j = $urandom_range(0, used_n - 1);
    mid = (j < NCLS - 1) ? (17'(size_tbl[j]) + 17'(size_tbl[j+1])) >> 1 : 17'(size_tbl[j]);
    case ($urandom_range(0, 5))
      0:       return size_tbl[j];
      1:       return size_tbl[j] + SIZE_W'($urandom_range(1, 40));
      2:       return size_tbl[j] - SIZE_W'($urandom_range(1, 40));
      3:       return mid[SIZE_W-1:0];
      4:       return SIZE_W'($urandom);
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  function automatic logic [MASS_W-1:0] pick_mass();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return MASS_W'($urandom_range(1, 7));
      default: return $urandom;
    endcase
  endfunction

  // mostly deposits with random read-outs and clears; some reloads keep the table sorted,
  // the rest scramble it
  task automatic random_phase(input int items);
    int               r;
    int               s;
    logic [SIZE_W:0]  mid;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 66) begin
        send_cmd(CMD_DEPOSIT, SLOT_W'($urandom), pick_size(), pick_mass());
      end else if (r < 80) begin
        send_cmd(CMD_READOUT, SLOT_W'($urandom), SIZE_W'($urandom), $urandom);
      end else if (r < 88) begin
        s   = $urandom_range(1, NCLS - 2);
        mid = (17'(size_tbl[s-1]) + 17'(size_tbl[s+1])) >> 1;
        send_cmd(CMD_LOAD, SLOT_W'(s), mid[SIZE_W-1:0], $urandom);
      end else if (r < 93) begin
        send_cmd(CMD_CLEAR, SLOT_W'($urandom), SIZE_W'($urandom), $urandom);
      end else begin
        send_cmd(CMD_LOAD, SLOT_W'($urandom), SIZE_W'($urandom), $urandom);
      end
    end
    send_cmd(CMD_READOUT, SLOT_W'($urandom), SIZE_W'($urandom), $urandom);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // evenly spread table covering 0 up to full scale, every slot written
    for (int i = 0; i < NCLS; i++)
      send_cmd(CMD_LOAD, SLOT_W'(i), SIZE_W'(i * 4369), $urandom);

    // reset setting: proportional, one class, all mass lands in class 0
    send_cmd(CMD_DEPOSIT, 4'd0, 16'd100, 32'h0001_0000);
    send_cmd(CMD_READOUT, 4'd0, 16'd0, 32'd0);

    // proportional over all classes: exact hits, end classes, splits
    set_mode(1'b1, CFG_DATA_W'(NCLS));
    send_cmd(CMD_DEPOSIT, 4'd0, 16'd0, 32'h0001_0000);      // first class exact
    send_cmd(CMD_DEPOSIT, 4'd0, 16'hffff, 32'hffff_ffff);   // last class exact
    send_cmd(CMD_DEPOSIT, 4'd0, 16'd5369, 32'hffff_ffff);   // split, full mass
    send_cmd(CMD_DEPOSIT, 4'd0, 16'd2000, 32'd3);           // split, floor shows
    send_cmd(CMD_DEPOSIT, 4'd0, 16'd4369, 32'd1);           // inner exact match
    send_cmd(CMD_DEPOSIT, 4'd0, 16'hfffe, $urandom);        // split below the top
    send_cmd(CMD_READOUT, 4'd0, 16'd0, 32'd0);
    send_cmd(CMD_CLEAR, 4'd0, 16'd0, 32'd0);
    send_cmd(CMD_READOUT, 4'd0, 16'd0, 32'd0);

    // nearest class mode, including ties that must go to the lower index
    set_mode(1'b0, CFG_DATA_W'(NCLS));
    send_cmd(CMD_DEPOSIT, 4'd0, 16'd2184, $urandom);
    send_cmd(CMD_DEPOSIT, 4'd0, 16'd2185, $urandom);
    send_cmd(CMD_DEPOSIT, 4'd0, 16'd0, 32'hffff_ffff);
    send_cmd(CMD_DEPOSIT, 4'd0, 16'hffff, $urandom);
    send_cmd(CMD_LOAD, 4'd2, 16'd4369, 32'd0);               // duplicate size, order fault
    send_cmd(CMD_DEPOSIT, 4'd0, 16'd4369, $urandom);         // zero distance tie
    send_cmd(CMD_LOAD, 4'd3, 16'd4569, 32'd0);
    send_cmd(CMD_DEPOSIT, 4'd0, 16'd4469, $urandom);         // equal distance tie
    send_cmd(CMD_READOUT, 4'd0, 16'd0, 32'd0);
    send_cmd(CMD_LOAD, 4'd2, 16'd8738, 32'd0);
    send_cmd(CMD_LOAD, 4'd3, 16'd13107, 32'd0);

    // saturation: class count zero acts as one, 257 full deposits pass 2^40-1,
    // the mark must survive further deposits and fall only on a clear
    set_mode(1'b0, '0);
    idle_on = 1'b0;
    send_cmd(CMD_CLEAR, 4'd0, 16'd0, 32'd0);
    repeat (257) send_cmd(CMD_DEPOSIT, SLOT_W'($urandom), SIZE_W'($urandom), '1);
    send_cmd(CMD_READOUT, 4'd0, 16'd0, 32'd0);
    send_cmd(CMD_DEPOSIT, 4'd0, 16'd9, 32'd12345);
    send_cmd(CMD_READOUT, 4'd0, 16'd0, 32'd0);
    send_cmd(CMD_CLEAR, 4'd0, 16'd0, 32'd0);
    send_cmd(CMD_READOUT, 4'd0, 16'd0, 32'd0);
    idle_on = 1'b1;

    // random phases across settings, class counts beyond the table among them
    set_mode(1'b1, CFG_DATA_W'(NCLS));
    random_phase(PHASE_ITEMS);

    set_mode(1'b0, 5'd31);
    idle_on = 1'b0;                       // a stretch with no gaps on either side
    random_phase(PHASE_ITEMS);
    idle_on = 1'b1;

    set_mode(1'b1, 5'd17);
    load_table(1'b1);
    random_phase(PHASE_ITEMS / 2);
    drain();                              // sender pauses until all totals are out
    random_phase(PHASE_ITEMS / 2);

    set_mode(1'b0, 5'd5);
    load_table(1'b0);
    random_phase(PHASE_ITEMS);

    set_mode(1'b1, 5'd1);
    random_phase(PHASE_ITEMS);

    // receiver holds off while full read-outs pile up behind it
    set_mode(1'b1, CFG_DATA_W'(NCLS));
    load_table(1'b1);
    hold_reqs++;
    repeat (3) send_cmd(CMD_READOUT, SLOT_W'($urandom), SIZE_W'($urandom), $urandom);
    random_phase(PHASE_ITEMS);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[size_class_mass_rebinning] OK");
    end else begin
      $display("[size_class_mass_rebinning] ERROR");
    end
    $finish;
  end

endmodule

### size_class_mass_rebinning.f
hdl/scm_pkg.sv
hdl/scm_divider.sv
hdl/size_class_mass_rebinning.sv
test/size_class_mass_rebinning_checker.sv
test/tb_size_class_mass_rebinning.sv
